@@ design/tde_pkg.sv @@
// Shared types and constants for the temporal difference encoder.
`timescale 1ns / 1ps

package tde_pkg;

   // Index bits that a record carries (bits above 17 are never emitted)
   localparam int IndexBits = 18;

   localparam int DimBits   = 10;
   localparam int PosBits   = 18;
   localparam int CountBits = 20;
   localparam int TotalBits = 2 * DimBits;
   localparam int JobDepth  = 6;
   localparam int JobBits   = 3;
   localparam int WordBits  = 24;

   localparam logic [DimBits-1:0] MaxDim = DimBits'(512);
   localparam logic [WordBits-1:0] IndexMask = WordBits'((64'd1 << IndexBits) - 64'd1);

   // Configuration register indexes
   localparam logic CsrRows    = 1'b0;
   localparam logic CsrColumns = 1'b1;

   typedef enum logic [1:0] {
      KIND_RECORD  = 2'd0,
      KIND_TRAILER = 2'd1,
      KIND_ERROR   = 2'd2
   } byte_kind_type;

   typedef struct packed {
      logic [7:0]    data;
      byte_kind_type kind;
   } slot_type;

endpackage

@@ design/temporal_difference_encoder.sv @@
// Top level of the temporal difference encoder: pixel pairs in, byte stream out.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_ready  reference_pixel, current_pixel
//   rsp_      out        rsp_valid/rsp_ready  out_byte, byte_kind, last_in_run, end_of_frame
//   csr_      in         csr_write_enable     csr_index, csr_write_data
//
// A request's output bytes leave through the one-byte output port in order: 3 for an
// in-range changed pixel, 1 error byte for an out-of-range one, up to 6 at the last pixel.
// A request is taken while the last byte of the previous request is being delivered.
// Reset is synchronous: position, byte count, failure flag and output buffer clear,
// rows and columns return to 512. An output stall holds the buffer and the input.
`timescale 1ns / 1ps

module temporal_difference_encoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_reference_pixel,
   input  logic [7:0] req_current_pixel,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_byte_kind,
   output logic       rsp_last_in_run,
   output logic       rsp_end_of_frame,
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic [9:0] csr_write_data
);

   logic [tde_pkg::DimBits-1:0]   rows_ff, columns_ff;
   logic [tde_pkg::PosBits-1:0]   position_ff, position_in;
   logic [tde_pkg::CountBits-1:0] byte_count_ff, byte_count_in;
   logic                          failed_ff, failed_in;
   tde_pkg::slot_type             slot_ff [tde_pkg::JobDepth];
   tde_pkg::slot_type             slot_in [tde_pkg::JobDepth];
   logic [tde_pkg::JobBits-1:0]   fill_ff, fill_in;
   logic                          eof_ff, eof_in;

   logic [tde_pkg::DimBits-1:0]   rows_eff, columns_eff;
   logic [tde_pkg::TotalBits-1:0] total_last;
   logic                          frame_end;
   logic [7:0]                    diff;
   logic                          in_range, emit_rec, emit_err, emit_trailer;
   logic [tde_pkg::CountBits-1:0] count_rec;
   logic [tde_pkg::WordBits-1:0]  idx_word;
   tde_pkg::slot_type             job [tde_pkg::JobDepth];
   logic [tde_pkg::JobBits-1:0]   job_fill;
   logic                          req_take, rsp_take;

   // Clamp the frame size and find the last pixel position
   always_comb begin
      rows_eff    = (rows_ff == '0) ? tde_pkg::DimBits'(1) :
                    (rows_ff > tde_pkg::MaxDim) ? tde_pkg::MaxDim : rows_ff;
      columns_eff = (columns_ff == '0) ? tde_pkg::DimBits'(1) :
                    (columns_ff > tde_pkg::MaxDim) ? tde_pkg::MaxDim : columns_ff;
      total_last  = (tde_pkg::TotalBits'(rows_eff) * tde_pkg::TotalBits'(columns_eff))
                    - tde_pkg::TotalBits'(1);
      frame_end   = tde_pkg::TotalBits'(position_ff) >= total_last;
   end

   // Classify the difference and build the bytes this request causes
   always_comb begin
      diff         = req_current_pixel - req_reference_pixel;
      in_range     = (diff < 8'd32) || (diff >= 8'd224);
      emit_rec     = !failed_ff && (diff != 8'd0) && in_range;
      emit_err     = !failed_ff && (diff != 8'd0) && !in_range;
      emit_trailer = frame_end && !failed_ff && !emit_err;
      count_rec    = emit_rec ? byte_count_ff + tde_pkg::CountBits'(3) : byte_count_ff;
      idx_word     = tde_pkg::WordBits'(position_ff) & tde_pkg::IndexMask;

      for (int i = 0; i < tde_pkg::JobDepth; i++) begin
         job[i] = '{data: 8'd0, kind: tde_pkg::KIND_RECORD};
      end
      job_fill = '0;
      if (emit_rec) begin
         job[0] = '{data: idx_word[7:0],  kind: tde_pkg::KIND_RECORD};
         job[1] = '{data: idx_word[15:8], kind: tde_pkg::KIND_RECORD};
         job[2] = '{data: {diff[5:0], idx_word[17:16]}, kind: tde_pkg::KIND_RECORD};
         if (emit_trailer) begin
            job[3] = '{data: count_rec[7:0],   kind: tde_pkg::KIND_TRAILER};
            job[4] = '{data: count_rec[15:8],  kind: tde_pkg::KIND_TRAILER};
            job[5] = '{data: {4'd0, count_rec[19:16]}, kind: tde_pkg::KIND_TRAILER};
            job_fill = tde_pkg::JobBits'(6);
         end else begin
            job_fill = tde_pkg::JobBits'(3);
         end
      end else if (emit_err) begin
         job[0]   = '{data: diff, kind: tde_pkg::KIND_ERROR};
         job_fill = tde_pkg::JobBits'(1);
      end else if (emit_trailer) begin
         job[0]   = '{data: count_rec[7:0],   kind: tde_pkg::KIND_TRAILER};
         job[1]   = '{data: count_rec[15:8],  kind: tde_pkg::KIND_TRAILER};
         job[2]   = '{data: {4'd0, count_rec[19:16]}, kind: tde_pkg::KIND_TRAILER};
         job_fill = tde_pkg::JobBits'(3);
      end
   end

   // Handshakes: take a request once the buffer is empty or drains this cycle
   assign rsp_valid        = fill_ff != '0;
   assign rsp_take         = rsp_valid && rsp_ready;
   assign req_ready        = (fill_ff == '0) ||
                             ((fill_ff == tde_pkg::JobBits'(1)) && rsp_ready);
   assign req_take         = req_valid && req_ready;
   assign rsp_out_byte     = slot_ff[0].data;
   assign rsp_byte_kind    = slot_ff[0].kind;
   assign rsp_last_in_run  = fill_ff == tde_pkg::JobBits'(1);
   assign rsp_end_of_frame = rsp_last_in_run && eof_ff;

   // Next frame state and buffer contents
   always_comb begin
      position_in   = position_ff;
      byte_count_in = byte_count_ff;
      failed_in     = failed_ff;
      fill_in       = fill_ff;
      eof_in        = eof_ff;
      for (int i = 0; i < tde_pkg::JobDepth; i++) begin
         slot_in[i] = slot_ff[i];
      end
      if (req_take) begin
         if (frame_end) begin
            position_in   = '0;
            byte_count_in = '0;
            failed_in     = 1'b0;
         end else begin
            position_in   = position_ff + tde_pkg::PosBits'(1);
            byte_count_in = count_rec;
            failed_in     = failed_ff || emit_err;
         end
         for (int i = 0; i < tde_pkg::JobDepth; i++) begin
            slot_in[i] = job[i];
         end
         fill_in = job_fill;
         eof_in  = emit_err || emit_trailer;
      end else if (rsp_take) begin
         // advance the byte queue by one
         for (int i = 0; i < tde_pkg::JobDepth - 1; i++) begin
            slot_in[i] = slot_ff[i + 1];
         end
         fill_in = fill_ff - tde_pkg::JobBits'(1);
      end
   end

   // Hold control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff       <= tde_pkg::MaxDim;
         columns_ff    <= tde_pkg::MaxDim;
         position_ff   <= '0;
         byte_count_ff <= '0;
         failed_ff     <= 1'b0;
         fill_ff       <= '0;
         eof_ff        <= 1'b0;
      end else begin
         position_ff   <= position_in;
         byte_count_ff <= byte_count_in;
         failed_ff     <= failed_in;
         fill_ff       <= fill_in;
         eof_ff        <= eof_in;
         if (csr_write_enable && (csr_index == tde_pkg::CsrRows)) begin
            rows_ff <= csr_write_data;
         end
         if (csr_write_enable && (csr_index == tde_pkg::CsrColumns)) begin
            columns_ff <= csr_write_data;
         end
      end
   end

   // Hold output bytes
   always_ff @(posedge clock) begin
      for (int i = 0; i < tde_pkg::JobDepth; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

`ifndef SYNTHESIS
   a_job_shows: assert property (@(posedge clock) disable iff (reset)
      (req_take && (job_fill != '0)) |=> rsp_valid)
      else $error("accepted request with output bytes shows nothing");

   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_end_of_frame) |-> rsp_last_in_run)
      else $error("end of frame on a byte that is not last of its request");

   a_trailer_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rsp_end_of_frame && (rsp_byte_kind == tde_pkg::KIND_TRAILER))
      |-> ((position_ff == '0) && (byte_count_ff == '0) && !failed_ff))
      else $error("frame state not cleared at trailer");

   a_failed_quiet: assert property (@(posedge clock) disable iff (reset)
      (failed_ff && req_take) |-> (job_fill == '0))
      else $error("failed frame emits bytes");
`endif

endmodule
